@@ design/assert_macros.svh @@
// Assertion macros used by the checker module of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

@@ design/sfm_pkg.sv @@
// Package for the substring first-match core: sizes, register indexes, payload types.
// No dependencies.
`timescale 1ns / 1ps

package sfm_pkg;

    localparam int NEEDLE_MAX    = 32;
    localparam int POSITION_BITS = 16;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 6;
    localparam int WORD_W        = 64;
    localparam int WORDS         = 4;
    localparam int BYTES_PER_WORD = WORD_W / BYTE_W;
    localparam int IDX_W         = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int CFG_IDX_W     = 3;
    localparam int POS_W         = 16;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LEN    = 3'd0,
        REG_NEEDLE_W0  = 3'd1,
        REG_NEEDLE_W1  = 3'd2,
        REG_NEEDLE_W2  = 3'd3,
        REG_NEEDLE_W3  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] hay_byte;
        logic              hay_last;
    } hay_item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_start;
    } result_item_t;

endpackage

@@ design/sfm_cell.sv @@
// One cell of the shift-and row: holds one prefix-match bit and compares one needle byte.
// Depends on sfm_pkg.
`timescale 1ns / 1ps

module sfm_cell
    import sfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              clear,
    input  logic              enable,
    input  logic              prev_match,
    input  logic [BYTE_W-1:0] needle_byte,
    input  logic [BYTE_W-1:0] hay_byte,
    output logic              step_match,
    output logic              match
);

    logic match_reg;
    logic match_next;

    // prefix through this byte ends here if the shorter prefix ended one byte ago
    assign step_match = prev_match & enable & (hay_byte == needle_byte);

    always_comb
    begin
        if (clear)
        begin
            match_next = 1'b0;
        end
        else if (advance)
        begin
            match_next = step_match;
        end
        else
        begin
            match_next = match_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

@@ design/sfm_out_buf.sv @@
// Output register with a skid stage for result transfers.
// Depends on sfm_pkg.
`timescale 1ns / 1ps

module sfm_out_buf
    import sfm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  result_item_t push_item,
    output logic         full,
    output logic         out_valid,
    input  logic         out_stall,
    output result_item_t out_item
);

    logic         out_valid_reg;
    logic         out_valid_next;
    result_item_t out_item_reg;
    result_item_t out_item_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    result_item_t skid_item_reg;
    result_item_t skid_item_next;
    logic         take;

    // output stage can load when empty or being drained this cycle
    assign take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_item_next  = push_item;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ design/substring_first_match_core.sv @@
// Substring first-match core: shift-and cell row, position counter, result buffer.
// A result is registered in the output register, or in the skid stage while the output is
// stalled, after the transfer of the byte that causes it. Throughput: one haystack byte per
// cycle while in_stall is low, set by the cell row update; in_stall rises only when both the
// output register and the skid stage hold results. Reset clears needle registers, scan state
// and the result buffer. Depends on sfm_pkg, sfm_cell, sfm_out_buf.
`timescale 1ns / 1ps

module substring_first_match_core
    import sfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // haystack byte channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  hay_item_t            in_item,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output result_item_t         out_item,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]  pat_len_reg;
    logic [WORD_W-1:0] needle_reg [WORDS];
    logic              cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg <= '0;
            for (int w = 0; w < WORDS; w++)
            begin
                needle_reg[w] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PAT_LEN:    pat_len_reg    <= cfg_data[LEN_W-1:0];
                REG_NEEDLE_W0:  needle_reg[0]  <= cfg_data;
                REG_NEEDLE_W1:  needle_reg[1]  <= cfg_data;
                REG_NEEDLE_W2:  needle_reg[2]  <= cfg_data;
                REG_NEEDLE_W3:  needle_reg[3]  <= cfg_data;
                default:        ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // Clamp the length to the row size; an empty needle matches at the first byte.
    logic [LEN_W-1:0] len_eff;
    logic [IDX_W-1:0] len_m1;
    logic             len_zero;

    assign len_eff  = (pat_len_reg > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX)
                                                         : pat_len_reg;
    assign len_zero = (len_eff == '0);
    assign len_m1   = IDX_W'(len_eff - LEN_W'(1));

    // ------------------------------------------------------------------
    // Scan state: position counter and reported flag.
    // ------------------------------------------------------------------
    logic                     accept;
    logic                     reported_reg;
    logic                     reported_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic                     advance;
    logic                     clear;

    assign accept  = in_valid & !in_stall;
    // Cells shift only while searching with a non-empty needle.
    assign advance = accept & !reported_reg & !len_zero;
    // Last byte of a haystack always clears the scan.
    assign clear   = accept & in_item.hay_last;

    // ------------------------------------------------------------------
    // Cell row: cell i holds "needle bytes 0..i end at the latest byte".
    // Each cell hands its bit to its right neighbor on every advance.
    // ------------------------------------------------------------------
    logic [NEEDLE_MAX-1:0] row_match;
    logic [NEEDLE_MAX-1:0] row_step;

    for (genvar i = 0; i < NEEDLE_MAX; i++)
    begin : g_cell
        logic prev_match;

        if (i == 0)
        begin : g_head
            assign prev_match = 1'b1;
        end
        else
        begin : g_body
            assign prev_match = row_match[i-1];
        end

        sfm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .clear       (clear),
            .enable      (len_eff > LEN_W'(i)),
            .prev_match  (prev_match),
            .needle_byte (needle_reg[i / BYTES_PER_WORD]
                                     [(i % BYTES_PER_WORD) * BYTE_W +: BYTE_W]),
            .hay_byte    (in_item.hay_byte),
            .step_match  (row_step[i]),
            .match       (row_match[i])
        );
    end

    // ------------------------------------------------------------------
    // Hit detect and start offset. Full needle completes when the cell at
    // the needle's last byte matches on this byte.
    // ------------------------------------------------------------------
    logic                     hit;
    logic [POSITION_BITS-1:0] start_pos;
    logic                     res_push;
    result_item_t             res_item;

    assign hit = !reported_reg & (len_zero | row_step[len_m1]);

    always_comb
    begin
        if (len_zero)
        begin
            start_pos = '0;
        end
        else if (pos_reg == POS_MAX)
        begin
            // counter is pinned: report the saturated value
            start_pos = POS_MAX;
        end
        else
        begin
            start_pos = pos_reg - POSITION_BITS'(len_m1);
        end
    end

    // One result per haystack: the first hit, or not found at the last byte.
    assign res_push             = accept & !reported_reg & (hit | in_item.hay_last);
    assign res_item.found       = hit;
    assign res_item.match_start = hit ? POS_W'(start_pos) : '0;

    always_comb
    begin
        reported_next = reported_reg;
        pos_next      = pos_reg;
        if (accept)
        begin
            if (in_item.hay_last)
            begin
                reported_next = 1'b0;
                pos_next      = '0;
            end
            else if (!reported_reg)
            begin
                reported_next = hit;
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + POSITION_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg <= 1'b0;
            pos_reg      <= '0;
        end
        else
        begin
            reported_reg <= reported_next;
            pos_reg      <= pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer: output register plus skid stage; hold input only when
    // the skid stage is occupied.
    // ------------------------------------------------------------------
    sfm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_item (res_item),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

@@ design/sfm_checker.sv @@
// Port-level checker for the substring first-match core, bound to the top level.
// Depends on sfm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfm_checker
    import sfm_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         in_stall,
    input logic         out_valid,
    input logic         out_stall,
    input result_item_t out_item
);

    `ASSERT_CLK(a_not_found_zero, clk, rst_n, (out_valid && !out_item.found) |-> (out_item.match_start == '0), "not-found result carries a nonzero offset")
    `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_item)), "stalled result dropped or changed")
    `ASSERT_NEVER(a_stall_needs_out, clk, rst_n, in_stall && !out_valid, "input held while output register is empty")
    `ASSERT_CLK(a_stall_cause, clk, rst_n, $rose(in_stall) |-> $past(out_valid && out_stall), "input hold raised without a stalled result")

endmodule

bind substring_first_match_core sfm_checker u_sfm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

@@ verif/testbench.sv @@
// Testbench for substring_first_match_core: streams haystacks and needle register writes,
// predicts the first-match result of each haystack and checks the results in order.
// Depends on sfm_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import sfm_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_BYTES   = 150;
    localparam int RUN_LIMIT_NS  = 5_000_000;
    localparam int MAX_REPORTS   = 40;
    localparam int LEN_CODE_MAX  = (1 << LEN_W) - 1;

    // Index outside the register map; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [CFG_IDX_W-1:0] addr;
        logic [WORD_W-1:0]    data;
    } reg_write_t;

    // Shift-and predictor plus the queue of results still owed by the core.
    class match_scoreboard;
        logic [LEN_W-1:0]      pat_len;
        logic [WORD_W-1:0]     needle_words [WORDS];
        logic [NEEDLE_MAX-1:0] prefix_bits;
        logic [POS_W-1:0]      position;
        bit                    reported;
        result_item_t          awaited [$];
        int                    errors;
        int                    checked;

        function new();
            pat_len = '0;
            foreach (needle_words[w])
                needle_words[w] = '0;
            clear_scan();
            errors  = 0;
            checked = 0;
        endfunction

        function void clear_scan();
            prefix_bits = '0;
            position    = '0;
            reported    = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] addr, logic [WORD_W-1:0] data);
            case (addr)
                REG_PAT_LEN:    pat_len         = data[LEN_W-1:0];
                REG_NEEDLE_W0:  needle_words[0] = data;
                REG_NEEDLE_W1:  needle_words[1] = data;
                REG_NEEDLE_W2:  needle_words[2] = data;
                REG_NEEDLE_W3:  needle_words[3] = data;
                default: ;
            endcase
        endfunction

        function void note_byte(hay_item_t item);
            logic [NEEDLE_MAX-1:0] byte_hits;
            logic [POS_W-1:0]      start;
            logic                  hit;
            int unsigned           len;
            len = (pat_len > NEEDLE_MAX) ? NEEDLE_MAX : pat_len;
            if (!reported)
            begin
                hit   = 1'b0;
                start = '0;
                if (len == 0)
                    hit = 1'b1;
                else
                begin
                    byte_hits = '0;
                    for (int i = 0; i < len; i++)
                        if (needle_words[i / BYTES_PER_WORD][(i % BYTES_PER_WORD) * BYTE_W +: BYTE_W]
                            == item.hay_byte)
                            byte_hits[i] = 1'b1;
                    prefix_bits = {prefix_bits[NEEDLE_MAX-2:0], 1'b1} & byte_hits;
                    if (prefix_bits[len-1])
                    begin
                        hit   = 1'b1;
                        start = (position == POS_MAX) ? POS_MAX : position - POS_W'(len - 1);
                    end
                end
                if (hit)
                begin
                    reported = 1'b1;
                    awaited.push_back('{found: 1'b1, match_start: start});
                end
                else if (item.hay_last)
                    awaited.push_back('{found: 1'b0, match_start: '0});
                if (position != POS_MAX)
                    position++;
            end
            if (item.hay_last)
                clear_scan();
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch: %s", what);
        endtask

        task check_result(result_item_t got);
            result_item_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending: found=%0b start=%0d",
                                          got.found, got.match_start));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.found !== want.found)
                report_mismatch($sformatf("found %0b, predicted %0b", got.found, want.found));
            if (got.match_start !== want.match_start)
                report_mismatch($sformatf("match_start %0d, predicted %0d",
                                          got.match_start, want.match_start));
        endtask
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    hay_item_t            in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    result_item_t         out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    match_scoreboard sb = new();

    // Needle as last programmed, byte by byte, and the byte pool for this phase.
    bit [BYTE_W-1:0] needle [NEEDLE_MAX];
    bit [BYTE_W-1:0] alphabet [3];
    int unsigned     needle_code = 0;
    reg_write_t      reg_writes [$];

    // Odds of starting an idle burst: one chance in N on each check, zero turns idling off.
    int unsigned gap_odds   = 0;
    int unsigned stall_odds = 0;

    int unsigned bytes_sent     = 0;
    int unsigned hays_sent      = 0;
    int unsigned settings_used  = 0;

    always #HALF_PERIOD clk = ~clk;

    substring_first_match_core i_dut (.*);

    // Check every result transfer against the oldest prediction.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);

    // Hold off the result channel in random bursts.
    initial
    begin : result_backpressure
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one haystack byte, maybe after an idle burst, and hold it until the transfer.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{hay_byte: b, hay_last: last};
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte('{hay_byte: b, hay_last: last});
        bytes_sent++;
    endtask

    // Drop valid, wait for every owed result, then let trailing bytes settle.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_reg(input logic [CFG_IDX_W-1:0] addr, input logic [WORD_W-1:0] data);
        reg_writes.push_back('{addr, data});
    endtask

    // Upper bits of the length write are junk; only the low field may count.
    task automatic queue_len(input int unsigned code);
        needle_code = code;
        queue_reg(REG_PAT_LEN, {$urandom, $urandom} & ~WORD_W'(LEN_CODE_MAX) | WORD_W'(code));
    endtask

    // Issue the queued register writes back to back; valid stays up between them.
    task automatic flush_regs();
        reg_write_t w;
        while (reg_writes.size() != 0)
        begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.addr;
            cfg_data  <= w.data;
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.write_reg(w.addr, w.data);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [WORD_W-1:0] needle_word(input int w);
        logic [WORD_W-1:0] word;
        for (int i = 0; i < BYTES_PER_WORD; i++)
            word[i * BYTE_W +: BYTE_W] = needle[w * BYTES_PER_WORD + i];
        return word;
    endfunction

    task automatic queue_all_words();
        for (int w = 0; w < WORDS; w++)
            queue_reg(CFG_IDX_W'(REG_NEEDLE_W0 + w), needle_word(w));
    endtask

    // Mostly bytes of a small pool so that partial matches overlap; sometimes any byte.
    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 3) != 0)
            return alphabet[$urandom_range(0, 2)];
        return BYTE_W'($urandom);
    endfunction

    function automatic int unsigned pick_len_code();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return NEEDLE_MAX;
            2:       return $urandom_range(NEEDLE_MAX + 1, LEN_CODE_MAX);
            3:       return $urandom_range(9, NEEDLE_MAX - 1);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int unsigned pick_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 10;
        endcase
    endfunction

    // New byte pool; rewrite all needle words or a random subset of them, then the length.
    task automatic program_needle(input int unsigned code, input bit all_words);
        foreach (alphabet[k])
            alphabet[k] = BYTE_W'($urandom);
        for (int w = 0; w < WORDS; w++)
            if (all_words || $urandom_range(0, 2) != 0)
            begin
                for (int i = 0; i < BYTES_PER_WORD; i++)
                    needle[w * BYTES_PER_WORD + i] = pick_byte();
                queue_reg(CFG_IDX_W'(REG_NEEDLE_W0 + w), needle_word(w));
            end
        queue_len(code);
        flush_regs();
    endtask

    // Random haystack: usually holds the needle, sometimes only a cut-off head of it.
    task automatic random_haystack();
        logic [BYTE_W-1:0] hay [$];
        int unsigned       eff;
        int unsigned       hay_len;
        int unsigned       at;
        int unsigned       keep;
        eff     = (needle_code > NEEDLE_MAX) ? NEEDLE_MAX : needle_code;
        hay_len = $urandom_range(1, eff + 12);
        repeat (hay_len) hay.push_back(pick_byte());
        if (eff > 0 && hay_len >= eff && $urandom_range(0, 3) != 0)
        begin
            at   = $urandom_range(0, hay_len - eff);
            keep = ($urandom_range(0, 2) == 0) ? $urandom_range(1, eff) : eff;
            for (int i = 0; i < keep; i++)
                hay[at + i] = needle[i];
        end
        foreach (hay[i])
            send_byte(hay[i], i == hay.size() - 1);
        hays_sent++;
    endtask

    initial
    begin : stimulus
        int unsigned phase_start;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        gap_odds   = 4;
        stall_odds = 4;

        // Empty needle out of reset: the first byte of each haystack matches at 0,
        // later bytes of that haystack are ignored.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);

        // Two-byte needle: haystack shorter than the needle, then an offset match
        // followed by a second occurrence that must stay silent.
        quiesce();
        needle[0] = "A";
        needle[1] = "B";
        queue_all_words();
        queue_len(2);
        flush_regs();
        send_byte("A", 1'b1);
        send_byte("x", 1'b0);
        send_byte("A", 1'b0);
        send_byte("B", 1'b0);
        send_byte("A", 1'b0);
        send_byte("B", 1'b1);

        // Rewrite the needle inside a haystack: the prefix already seen is kept.
        send_byte("A", 1'b0);
        quiesce();
        needle[1] = "C";
        queue_reg(REG_NEEDLE_W0, needle_word(0));
        flush_regs();
        send_byte("C", 1'b1);

        // All-ones needle with the largest length code, clamped to the maximum.
        quiesce();
        foreach (needle[i])
            needle[i] = 8'hFF;
        queue_all_words();
        queue_len(LEN_CODE_MAX);
        flush_regs();
        send_byte(8'hFF, 1'b1);

        // A write to an unmapped index, then a one-byte needle of zero.
        quiesce();
        queue_reg(REG_UNUSED, {$urandom, $urandom});
        needle[0] = 8'h00;
        queue_reg(REG_NEEDLE_W0, needle_word(0));
        queue_len(1);
        flush_regs();
        send_byte(8'h00, 1'b1);

        // Random phases, each under a fresh needle; the last ones run without idling.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            quiesce();
            gap_odds   = (p >= RANDOM_PHASES - 2) ? 0 : pick_odds();
            stall_odds = (p >= RANDOM_PHASES - 2) ? 0 : pick_odds();
            if (p == 0)
                program_needle(NEEDLE_MAX, 1'b1);
            else if (p == 1)
                program_needle(LEN_CODE_MAX, 1'b1);
            else
                program_needle(pick_len_code(), 1'b0);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                random_haystack();
        end

        quiesce();
        $display("covered %0d haystack bytes (%0d random haystacks), %0d results checked",
                 bytes_sent, hays_sent, sb.checked);
        $display("under %0d needle settings, empty through clamped, with random idling",
                 settings_used);
        if (sb.errors == 0)
            $display("[substring_first_match_core] OK");
        else
            $display("[substring_first_match_core] ERROR");
        $finish;
    end

    // Hard stop in case the core hangs a handshake.
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("timeout with %0d results still pending", sb.awaited.size());
        $display("[substring_first_match_core] ERROR");
        $finish;
    end

endmodule
